>>> src/eight_bit_cpu_partial_execute_top_defines.svh
// ----------------------------------------------------------------------------
// eight_bit_cpu_partial_execute_top_defines.svh
// assertion macros shared by the execute block
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_PARTIAL_EXECUTE_TOP_DEFINES_SVH
`define EIGHT_BIT_CPU_PARTIAL_EXECUTE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define EBCPE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define EBCPE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EBCPE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define EBCPE_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> src/ebcpe_pkg.sv
// ----------------------------------------------------------------------------
// ebcpe_pkg
// types, opcodes and reset values for the partial eight-bit cpu execute block
// ----------------------------------------------------------------------------
`default_nettype none

package ebcpe_pkg;

    // opcodes
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LD_BC_NN = 8'h01;
    localparam logic [7:0] OP_LD_MBC_A = 8'h02;
    localparam logic [7:0] OP_INC_BC   = 8'h03;
    localparam logic [7:0] OP_INC_B    = 8'h04;
    localparam logic [7:0] OP_DEC_B    = 8'h05;
    localparam logic [7:0] OP_LD_B_N   = 8'h06;
    localparam logic [7:0] OP_RLCA     = 8'h07;
    localparam logic [7:0] OP_LD_NN_SP = 8'h08;
    localparam logic [7:0] OP_ADD_HLBC = 8'h09;
    localparam logic [7:0] OP_LD_A_MBC = 8'h0A;
    localparam logic [7:0] OP_DEC_BC   = 8'h0B;
    localparam logic [7:0] OP_INC_C    = 8'h0C;
    localparam logic [7:0] OP_DEC_C    = 8'h0D;
    localparam logic [7:0] OP_LD_C_N   = 8'h0E;
    localparam logic [7:0] OP_RRCA     = 8'h0F;
    localparam logic [7:0] OP_STOP     = 8'h10;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_DI       = 8'hF3;
    localparam logic [7:0] OP_EI       = 8'hFB;
    localparam logic [7:0] OP_PREFIX   = 8'hCB;

    // prefixed rlc operand codes
    localparam logic [2:0] CB_B  = 3'd0;
    localparam logic [2:0] CB_C  = 3'd1;
    localparam logic [2:0] CB_D  = 3'd2;
    localparam logic [2:0] CB_E  = 3'd3;
    localparam logic [2:0] CB_H  = 3'd4;
    localparam logic [2:0] CB_L  = 3'd5;
    localparam logic [2:0] CB_HL = 3'd6;
    localparam logic [2:0] CB_A  = 3'd7;

    // flag bit positions in the 4-bit flag register
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [15:0] SP_RESET = 16'hFFFE;
    localparam logic [15:0] PC_RESET = 16'h0100;

    localparam logic [4:0] CYC_4  = 5'd4;
    localparam logic [4:0] CYC_8  = 5'd8;
    localparam logic [4:0] CYC_12 = 5'd12;
    localparam logic [4:0] CYC_16 = 5'd16;
    localparam logic [4:0] CYC_20 = 5'd20;

    typedef struct packed {
        logic [7:0]  a;
        logic [3:0]  f;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
        logic [15:0] pc;
        logic        halt;
        logic        ime;
    } cpu_state_t;

    typedef struct packed {
        logic        we;
        logic        two;
        logic [15:0] addr0;
        logic [7:0]  data0;
        logic [15:0] addr1;
        logic [7:0]  data1;
    } wr_t;

    typedef struct packed {
        wr_t        wr;
        logic [4:0] cyc;
        cpu_state_t st;
    } res_t;

endpackage

`default_nettype wire

>>> src/ebcpe_exec.sv
// ----------------------------------------------------------------------------
// ebcpe_exec
// single-pass instruction decode and register update
// ----------------------------------------------------------------------------
`default_nettype none

module ebcpe_exec (
    input  wire ebcpe_pkg::cpu_state_t st_in,
    input  wire logic [7:0]            opcode,
    input  wire logic [7:0]            second_byte,
    input  wire logic [7:0]            third_byte,
    input  wire logic [7:0]            read_data,
    output ebcpe_pkg::res_t            res
);

    ebcpe_pkg::cpu_state_t st;
    ebcpe_pkg::wr_t        wr;
    logic [4:0]  cyc;
    logic [1:0]  len;
    logic [7:0]  rot_in;
    logic [7:0]  rot_out;
    logic [7:0]  inc_b, dec_b, inc_c, dec_c;
    logic [16:0] hl_sum;
    logic [12:0] hl_half;
    logic [15:0] nn;

    assign inc_b   = st_in.b + 8'd1;
    assign dec_b   = st_in.b - 8'd1;
    assign inc_c   = st_in.c + 8'd1;
    assign dec_c   = st_in.c - 8'd1;
    assign hl_sum  = {1'b0, st_in.h, st_in.l} + {1'b0, st_in.b, st_in.c};
    assign hl_half = {1'b0, st_in.h[3:0], st_in.l} + {1'b0, st_in.b[3:0], st_in.c};
    assign nn      = {third_byte, second_byte};

    // operand for the prefixed rlc
    always_comb begin
        case (second_byte[2:0])
            ebcpe_pkg::CB_B:  rot_in = st_in.b;
            ebcpe_pkg::CB_C:  rot_in = st_in.c;
            ebcpe_pkg::CB_D:  rot_in = st_in.d;
            ebcpe_pkg::CB_E:  rot_in = st_in.e;
            ebcpe_pkg::CB_H:  rot_in = st_in.h;
            ebcpe_pkg::CB_L:  rot_in = st_in.l;
            ebcpe_pkg::CB_HL: rot_in = read_data;
            default:          rot_in = st_in.a;
        endcase
    end

    assign rot_out = {rot_in[6:0], rot_in[7]};

    always_comb begin
        st  = st_in;
        wr  = '0;
        cyc = ebcpe_pkg::CYC_4;
        len = 2'd1;
        if (opcode == ebcpe_pkg::OP_PREFIX) begin
            len = 2'd2;
            cyc = ebcpe_pkg::CYC_8;
            if (second_byte inside {[8'd0:8'd7]}) begin
                st.f = {(rot_out == 8'd0), 1'b0, 1'b0, rot_in[7]};
                case (second_byte[2:0])
                    ebcpe_pkg::CB_B: st.b = rot_out;
                    ebcpe_pkg::CB_C: st.c = rot_out;
                    ebcpe_pkg::CB_D: st.d = rot_out;
                    ebcpe_pkg::CB_E: st.e = rot_out;
                    ebcpe_pkg::CB_H: st.h = rot_out;
                    ebcpe_pkg::CB_L: st.l = rot_out;
                    ebcpe_pkg::CB_HL: begin
                        wr.we    = 1'b1;
                        wr.addr0 = {st_in.h, st_in.l};
                        wr.data0 = rot_out;
                        cyc      = ebcpe_pkg::CYC_16;
                    end
                    default: st.a = rot_out;
                endcase
            end
        end else begin
            case (opcode)
                ebcpe_pkg::OP_LD_BC_NN: begin
                    st.c = second_byte;
                    st.b = third_byte;
                    len  = 2'd3;
                    cyc  = ebcpe_pkg::CYC_12;
                end
                ebcpe_pkg::OP_LD_MBC_A: begin
                    wr.we    = 1'b1;
                    wr.addr0 = {st_in.b, st_in.c};
                    wr.data0 = st_in.a;
                    cyc      = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_INC_BC: begin
                    {st.b, st.c} = {st_in.b, st_in.c} + 16'd1;
                    cyc          = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_INC_B: begin
                    st.b = inc_b;
                    st.f[ebcpe_pkg::FLAG_Z] = (inc_b == 8'd0);
                    st.f[ebcpe_pkg::FLAG_N] = 1'b0;
                    st.f[ebcpe_pkg::FLAG_H] = (inc_b[3:0] == 4'h0);
                end
                ebcpe_pkg::OP_DEC_B: begin
                    st.b = dec_b;
                    st.f[ebcpe_pkg::FLAG_Z] = (dec_b == 8'd0);
                    st.f[ebcpe_pkg::FLAG_N] = 1'b1;
                    st.f[ebcpe_pkg::FLAG_H] = (dec_b[3:0] == 4'hF);
                end
                ebcpe_pkg::OP_LD_B_N: begin
                    st.b = second_byte;
                    len  = 2'd2;
                    cyc  = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_RLCA: begin
                    st.a = {st_in.a[6:0], st_in.a[7]};
                    st.f = {3'b000, st_in.a[7]};
                end
                ebcpe_pkg::OP_LD_NN_SP: begin
                    wr.we    = 1'b1;
                    wr.two   = 1'b1;
                    wr.addr0 = nn;
                    wr.data0 = st_in.sp[7:0];
                    wr.addr1 = nn + 16'd1;
                    wr.data1 = st_in.sp[15:8];
                    len      = 2'd3;
                    cyc      = ebcpe_pkg::CYC_20;
                end
                ebcpe_pkg::OP_ADD_HLBC: begin
                    {st.h, st.l} = hl_sum[15:0];
                    st.f[ebcpe_pkg::FLAG_N] = 1'b0;
                    st.f[ebcpe_pkg::FLAG_H] = hl_half[12];
                    st.f[ebcpe_pkg::FLAG_C] = hl_sum[16];
                    cyc = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_LD_A_MBC: begin
                    st.a = read_data;
                    cyc  = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_DEC_BC: begin
                    {st.b, st.c} = {st_in.b, st_in.c} - 16'd1;
                    cyc          = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_INC_C: begin
                    st.c = inc_c;
                    st.f[ebcpe_pkg::FLAG_Z] = (inc_c == 8'd0);
                    st.f[ebcpe_pkg::FLAG_N] = 1'b0;
                    st.f[ebcpe_pkg::FLAG_H] = (inc_c[3:0] == 4'h0);
                end
                ebcpe_pkg::OP_DEC_C: begin
                    st.c = dec_c;
                    st.f[ebcpe_pkg::FLAG_Z] = (dec_c == 8'd0);
                    st.f[ebcpe_pkg::FLAG_N] = 1'b1;
                    st.f[ebcpe_pkg::FLAG_H] = (dec_c[3:0] == 4'hF);
                end
                ebcpe_pkg::OP_LD_C_N: begin
                    st.c = second_byte;
                    len  = 2'd2;
                    cyc  = ebcpe_pkg::CYC_8;
                end
                ebcpe_pkg::OP_RRCA: begin
                    st.a = {st_in.a[0], st_in.a[7:1]};
                    st.f = {3'b000, st_in.a[0]};
                end
                ebcpe_pkg::OP_STOP: begin
                    st.halt = 1'b1;
                    len     = 2'd2;
                end
                ebcpe_pkg::OP_HALT: st.halt = 1'b1;
                ebcpe_pkg::OP_DI:   st.ime  = 1'b0;
                ebcpe_pkg::OP_EI:   st.ime  = 1'b1;
                default: ;
            endcase
        end
        st.pc = st_in.pc + {14'd0, len};
    end

    assign res = '{wr: wr, cyc: cyc, st: st};

endmodule

`default_nettype wire

>>> src/ebcpe_result.sv
// ----------------------------------------------------------------------------
// ebcpe_result
// result register; plays out one or two write beats per instruction
// ----------------------------------------------------------------------------
`default_nettype none

module ebcpe_result (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire ebcpe_pkg::res_t       res_in,
    output logic                       free,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_write_enable,
    output logic [15:0]                m_write_address,
    output logic [7:0]                 m_write_data,
    output logic                       m_last,
    output logic [4:0]                 m_cycle_count,
    output logic [15:0]                m_next_pc,
    output logic                       m_halted_flag,
    output logic                       m_interrupts_enabled,
    output logic [15:0]                m_acc_and_flags,
    output logic [15:0]                m_pair_bc,
    output logic [15:0]                m_pair_de,
    output logic [15:0]                m_pair_hl
);

    ebcpe_pkg::res_t res_reg;
    logic            valid_reg;
    logic            beat_reg;
    logic            last_beat;

    assign last_beat = !res_reg.wr.two || beat_reg;
    assign free      = !valid_reg || (m_ready && last_beat);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            beat_reg  <= 1'b0;
        end else if (valid_reg && m_ready) begin
            if (last_beat) begin
                valid_reg <= 1'b0;
            end else begin
                beat_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid              = valid_reg;
    assign m_write_enable       = res_reg.wr.we;
    assign m_write_address      = beat_reg ? res_reg.wr.addr1 : res_reg.wr.addr0;
    assign m_write_data         = beat_reg ? res_reg.wr.data1 : res_reg.wr.data0;
    assign m_last               = last_beat;
    assign m_cycle_count        = res_reg.cyc;
    assign m_next_pc            = res_reg.st.pc;
    assign m_halted_flag        = res_reg.st.halt;
    assign m_interrupts_enabled = res_reg.st.ime;
    assign m_acc_and_flags      = {res_reg.st.a, res_reg.st.f, 4'b0000};
    assign m_pair_bc            = {res_reg.st.b, res_reg.st.c};
    assign m_pair_de            = {res_reg.st.d, res_reg.st.e};
    assign m_pair_hl            = {res_reg.st.h, res_reg.st.l};

endmodule

`default_nettype wire

>>> src/eight_bit_cpu_partial_execute_top.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_partial_execute_top
// partial eight-bit cpu core: one instruction executed per input item
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | opcode, second/third byte, read_data
//  m_      | out       | m_valid / m_ready | write beat, cycle count, pc, regs
//
//  an item is captured in the input register, is executed on the way into the
//  result register and is offered on m_ from there. one item per cycle while
//  m_ready stays high; ld (nn),sp holds the result register for two beats.
//  reset: registers zero, sp 0xfffe, pc 0x0100, both stages empty.
//  a stalled m_ side fills the result then the input register, then s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "eight_bit_cpu_partial_execute_top_defines.svh"

module eight_bit_cpu_partial_execute_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_opcode,
    input  wire logic [7:0]  s_second_byte,
    input  wire logic [7:0]  s_third_byte,
    input  wire logic [7:0]  s_read_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_write_enable,
    output logic [15:0]      m_write_address,
    output logic [7:0]       m_write_data,
    output logic             m_last,
    output logic [4:0]       m_cycle_count,
    output logic [15:0]      m_next_pc,
    output logic             m_halted_flag,
    output logic             m_interrupts_enabled,
    output logic [15:0]      m_acc_and_flags,
    output logic [15:0]      m_pair_bc,
    output logic [15:0]      m_pair_de,
    output logic [15:0]      m_pair_hl
);

    logic                  in_valid_reg;
    logic [7:0]            opcode_reg;
    logic [7:0]            second_reg;
    logic [7:0]            third_reg;
    logic [7:0]            rdata_reg;
    ebcpe_pkg::cpu_state_t state_reg;
    ebcpe_pkg::res_t       res_next;
    logic                  res_free;
    logic                  advance;

    assign advance = in_valid_reg && res_free;
    assign s_ready = !in_valid_reg || res_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg <= s_opcode;
            second_reg <= s_second_byte;
            third_reg  <= s_third_byte;
            rdata_reg  <= s_read_data;
        end
    end

    // architectural state moves with the item into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{sp: ebcpe_pkg::SP_RESET, pc: ebcpe_pkg::PC_RESET, default: '0};
        end else if (advance) begin
            state_reg <= res_next.st;
        end
    end

    ebcpe_exec u_exec (
        .st_in       (state_reg),
        .opcode      (opcode_reg),
        .second_byte (second_reg),
        .third_byte  (third_reg),
        .read_data   (rdata_reg),
        .res         (res_next)
    );

    ebcpe_result u_result (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .load                 (advance),
        .res_in               (res_next),
        .free                 (res_free),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_write_enable       (m_write_enable),
        .m_write_address      (m_write_address),
        .m_write_data         (m_write_data),
        .m_last               (m_last),
        .m_cycle_count        (m_cycle_count),
        .m_next_pc            (m_next_pc),
        .m_halted_flag        (m_halted_flag),
        .m_interrupts_enabled (m_interrupts_enabled),
        .m_acc_and_flags      (m_acc_and_flags),
        .m_pair_bc            (m_pair_bc),
        .m_pair_de            (m_pair_de),
        .m_pair_hl            (m_pair_hl)
    );

    // first write beat taken: the second beat follows and closes the item
    `EBCPE_ASSERT_NXT(a_second_beat, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_last && m_write_enable)

    // a non-write result is always a single beat with a cleared address and data
    `EBCPE_ASSERT_IMP(a_no_write_clean, aclk, aresetn, m_valid && !m_write_enable, m_last && (m_write_address == 16'd0) && (m_write_data == 8'd0))

    // the pc only moves when an item passes into the result register
    `EBCPE_ASSERT_NXT(a_pc_hold, aclk, aresetn, !advance, $stable(state_reg.pc))

    // reported pc is the committed pc
    `EBCPE_ASSERT_IMP(a_pc_match, aclk, aresetn, m_valid, m_next_pc == state_reg.pc)

endmodule

`default_nettype wire
